[hdl/window_level_to_gray8_top_assert.svh]
// Assertion macros for the window level block
`ifndef WINDOW_LEVEL_TO_GRAY8_TOP_ASSERT_SVH
`define WINDOW_LEVEL_TO_GRAY8_TOP_ASSERT_SVH
`ifndef SYNTH
`define WL_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("wl check failed");
`define WL_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("wl sequence check failed");
`else
`define WL_CHECK(lbl, cond)
`define WL_CHECK_NEXT(lbl, pre, post)
`endif
`endif

[hdl/wl_pkg.sv]
package wl_pkg;

  localparam int FRAC_BITS   = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int WIDTH_W     = VALUE_WIDTH - 1;
  localparam int DEN_W       = VALUE_WIDTH;
  localparam int GRAY_W      = 8;
  localparam int REM_W       = DEN_W + GRAY_W;
  localparam int DIV_STEPS   = GRAY_W;
  localparam int SUM_W       = VALUE_WIDTH + 3;

  localparam logic [WIDTH_W-1:0] ONE_W = WIDTH_W'(1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] TWO_ONE = SUM_W'(2 << FRAC_BITS);

  localparam logic [VALUE_WIDTH-1:0] CENTER_RESET = VALUE_WIDTH'(2048);
  localparam logic [WIDTH_W-1:0]     WIDTH_RESET  = WIDTH_W'(4096);

  localparam logic [GRAY_W-1:0] GRAY_MIN = '0;
  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

  typedef enum logic {
    REG_CENTER = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              force_out;
    logic [GRAY_W-1:0] fval;
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [GRAY_W-1:0] q;
  } wl_stage_t;

endpackage

[hdl/window_level_to_gray8_top.sv]
// Linear window/level mapping of signed fixed-point pixels (4 fraction bits) to
// 8-bit gray. One pixel is accepted every clock while the output is not stalled;
// each result passes through the difference, edge-test and scaling registers, the
// steps of a pipelined restoring divider that yields one quotient bit per stage,
// and the output register. A stall on the output freezes the whole pipeline.
// Write the center and width registers only while no pixel is in flight.
module window_level_to_gray8_top import wl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic                          reg_index,
  input  logic [VALUE_WIDTH-1:0]        write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] pixel_value,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [GRAY_W-1:0]             gray_level,
  output logic                          last_out
);

  logic signed [VALUE_WIDTH-1:0] center;
  logic [WIDTH_W-1:0]            width;
  logic                          en;
  wl_stage_t                     chain [DIV_STEPS+1];
  wl_stage_t                     fin;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign fin      = chain[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= CENTER_RESET;
      width  <= WIDTH_RESET;
    end else if (write_enable) begin
      case (reg_index_t'(reg_index))
        REG_CENTER: center <= write_data;
        REG_WIDTH:  width  <= write_data[WIDTH_W-1:0];
        default:    ;
      endcase
    end
  end

  wl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vld_in      (in_valid),
    .last_in     (last_in),
    .pixel_value (pixel_value),
    .center      (center),
    .width       (width),
    .s3          (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    wl_div_step u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .s_in  (chain[i]),
      .s_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_level <= fin.force_out ? fin.fval : fin.q;
      last_out   <= fin.last;
    end
  end

endmodule

[hdl/wl_front.sv]
`include "window_level_to_gray8_top_assert.svh"

module wl_front import wl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic                          last_in,
  input  logic signed [VALUE_WIDTH-1:0] pixel_value,
  input  logic signed [VALUE_WIDTH-1:0] center,
  input  logic [WIDTH_W-1:0]            width,
  output wl_stage_t                     s3
);

  logic                        s1_vld;
  logic                        s1_last;
  logic signed [VALUE_WIDTH:0] diff1;
  logic [WIDTH_W-1:0]          wn1;

  logic                        s2_vld;
  logic                        s2_last;
  logic                        zero2;
  logic                        sat2;
  logic [DEN_W-1:0]            num2;
  logic [DEN_W-1:0]            den2;

  logic signed [VALUE_WIDTH:0] diff_next;
  logic [WIDTH_W-1:0]          wn_next;
  logic signed [SUM_W-1:0]     d_ext;
  logic signed [SUM_W-1:0]     wn_ext;
  logic signed [SUM_W-1:0]     num_sum;
  logic signed [SUM_W-1:0]     hi_sum;
  wl_stage_t                   s3_next;

  // stage 1: difference to center, clamp width
  assign diff_next = {pixel_value[VALUE_WIDTH-1], pixel_value}
                   - {center[VALUE_WIDTH-1], center};
  assign wn_next   = (width < ONE_W) ? ONE_W : width;

  // stage 2: edge tests and divisor
  assign d_ext   = {diff1[VALUE_WIDTH], diff1, 1'b0};
  assign wn_ext  = {{(SUM_W-WIDTH_W){1'b0}}, wn1};
  assign num_sum = d_ext + wn_ext;
  assign hi_sum  = d_ext + TWO_ONE - wn_ext;

  // stage 3: scale numerator by 255
  always_comb begin
    s3_next.vld       = s2_vld;
    s3_next.last      = s2_last;
    s3_next.force_out = zero2 || sat2;
    s3_next.fval      = sat2 ? GRAY_MAX : GRAY_MIN;
    s3_next.rem       = {num2, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, num2};
    s3_next.den       = den2;
    s3_next.q         = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3.vld <= 1'b0;
    end else if (en) begin
      s1_vld <= vld_in;
      s2_vld <= s1_vld;
      s3.vld <= s3_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last      <= last_in;
      diff1        <= diff_next;
      wn1          <= wn_next;
      s2_last      <= s1_last;
      zero2        <= num_sum[SUM_W-1] || (num_sum == '0);
      sat2         <= !hi_sum[SUM_W-1] && (hi_sum != '0);
      num2         <= num_sum[DEN_W-1:0];
      den2         <= {wn1 - ONE_W, 1'b0};
      s3.last      <= s3_next.last;
      s3.force_out <= s3_next.force_out;
      s3.fval      <= s3_next.fval;
      s3.rem       <= s3_next.rem;
      s3.den       <= s3_next.den;
      s3.q         <= s3_next.q;
    end
  end

  `WL_CHECK_NEXT(a_enter, vld_in && en, s1_vld)
  `WL_CHECK_NEXT(a_hold, !en, $stable(s3))
  `WL_CHECK(a_edges_excl, !(s2_vld && zero2 && sat2))
  `WL_CHECK(a_rem_bound, !(s3.vld && !s3.force_out) || (s3.rem < {s3.den, {GRAY_W{1'b0}}}))

endmodule

[hdl/wl_div_step.sv]
module wl_div_step import wl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  wl_stage_t s_in,
  output wl_stage_t s_out
);

  logic [REM_W-1:0] dsh;
  logic [REM_W-1:0] diff;
  logic             take;
  wl_stage_t        s_next;

  // restoring step against den * 2^7, remainder shifted up each step
  assign dsh  = {1'b0, s_in.den, {(GRAY_W-1){1'b0}}};
  assign take = (s_in.rem >= dsh);
  assign diff = s_in.rem - dsh;

  always_comb begin
    s_next = s_in;
    if (!s_in.force_out) begin
      s_next.rem = take ? {diff[REM_W-2:0], 1'b0} : {s_in.rem[REM_W-2:0], 1'b0};
      s_next.q   = {s_in.q[GRAY_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out.vld <= 1'b0;
    end else if (en) begin
      s_out.vld <= s_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out.last      <= s_next.last;
      s_out.force_out <= s_next.force_out;
      s_out.fval      <= s_next.fval;
      s_out.rem       <= s_next.rem;
      s_out.den       <= s_next.den;
      s_out.q         <= s_next.q;
    end
  end

endmodule
